### design/cluster_buffer_lru_cache_macros.svh
// Assertion macros shared by the sector buffer cache modules.
// Needs a clk and an active-high rst in the module that expands them.
`ifndef CLUSTER_BUFFER_LRU_CACHE_MACROS_SVH
`define CLUSTER_BUFFER_LRU_CACHE_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define CBLC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// The property must hold in the cycle after the condition.
`define CBLC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### design/cblc_pkg.sv
// Shared types and constants of the sector buffer cache.
// Used by the controller, the datapath and the top level.
`default_nettype none

package cblc_pkg;

  // Default sizes of the cache.
  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_SECTOR_BITS = 32;
  localparam int DEF_AGE_BITS    = 32;

  // Fixed widths of the request and result fields.
  localparam int VOL_W    = 2;
  localparam int SECTOR_W = 32;
  localparam int TICK_W   = 32;
  localparam int ENTRY_W  = 4;

  // Operation codes of the func field.
  localparam logic FUNC_LOOKUP     = 1'b0;
  localparam logic FUNC_INVALIDATE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### design/cblc_ctrl.sv
// Controller of the sector buffer cache: sequencing and result handshake.
// Depends on cblc_pkg and the assertion macro header.
`default_nettype none
`include "cluster_buffer_lru_cache_macros.svh"

module cblc_ctrl #(
  parameter int ENTRIES = cblc_pkg::DEF_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cblc_pkg::ctrl_cmd_t     cmd
);

  // The minimum-age tree has one register level per index bit.
  localparam int LVL   = $clog2(ENTRIES);
  localparam int CNT_W = (LVL > 1) ? $clog2(LVL) : 1;

  cblc_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cblc_pkg::ST_IDLE: begin
        if (in_valid) state_next = cblc_pkg::ST_WAIT;
      end
      cblc_pkg::ST_WAIT: begin
        if (cnt == CNT_W'(LVL - 1)) state_next = cblc_pkg::ST_UPDATE;
      end
      cblc_pkg::ST_UPDATE: begin
        if (out_free) state_next = cblc_pkg::ST_IDLE;
      end
      default: state_next = cblc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      cblc_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      cblc_pkg::ST_WAIT: begin
        in_stall = 1'b1;
      end
      cblc_pkg::ST_UPDATE: begin
        cmd.commit = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Wait counter and result valid flag.
  always_comb begin
    cnt_next = (state == cblc_pkg::ST_WAIT) ? cnt + CNT_W'(1) : '0;
    if (cmd.commit) out_valid_next = 1'b1;
    else            out_valid_next = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cblc_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // A result is written only into a free output register.
  `CBLC_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || !out_stall, "commit over held result")
  // A new result appears only after a commit.
  `CBLC_ASSERT_NOW(a_valid_from_commit, $rose(out_valid), $past(cmd.commit), "result without commit")
  // The tree needs time after a request is taken: no commit comes in the cycle after a capture.
  `CBLC_ASSERT_NEXT(a_no_early_commit, cmd.capture, !cmd.commit, "commit right after capture")

endmodule

`default_nettype wire

### design/cblc_dp.sv
// Datapath of the sector buffer cache: tag store, match, minimum-age tree and result.
// Depends on cblc_pkg and the assertion macro header.
`default_nettype none
`include "cluster_buffer_lru_cache_macros.svh"

module cblc_dp #(
  parameter int ENTRIES     = cblc_pkg::DEF_ENTRIES,
  parameter int SECTOR_BITS = cblc_pkg::DEF_SECTOR_BITS,
  parameter int AGE_BITS    = cblc_pkg::DEF_AGE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cblc_pkg::ctrl_cmd_t            cmd,
  input  wire logic                           func,
  input  wire logic [cblc_pkg::VOL_W-1:0]     volume_id,
  input  wire logic [cblc_pkg::SECTOR_W-1:0]  sector,
  input  wire logic [cblc_pkg::TICK_W-1:0]    tick,
  input  wire logic [cblc_pkg::ENTRY_W-1:0]   target_entry,
  input  wire logic                           fill_failed,
  output logic                                hit,
  output logic [cblc_pkg::ENTRY_W-1:0]        entry,
  output logic                                fill_needed,
  output logic                                error
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int P     = 1 << IDX_W;
  localparam int NODES = 2 * P - 1;

  // Tag store, one register set per entry.
  logic                         entry_valid  [ENTRIES];
  logic [cblc_pkg::VOL_W-1:0]   entry_volume [ENTRIES];
  logic [SECTOR_BITS-1:0]       entry_sector [ENTRIES];
  logic [AGE_BITS-1:0]          entry_age    [ENTRIES];

  // Captured request.
  logic                         req_func;
  logic [cblc_pkg::VOL_W-1:0]   req_vol;
  logic [SECTOR_BITS-1:0]       req_sec;
  logic [AGE_BITS-1:0]          req_tick;
  logic [cblc_pkg::ENTRY_W-1:0] req_target;
  logic                         req_failed;

  logic [ENTRIES-1:0]           match_r;
  logic [IDX_W-1:0]             hit_idx;
  logic                         any_hit;
  logic [IDX_W-1:0]             tgt_idx;
  logic                         tgt_in_range;
  logic [IDX_W-1:0]             res_idx;

  // Minimum-age tree in heap order; leaves follow the internal nodes.
  logic                         tree_ok  [NODES];
  logic [AGE_BITS-1:0]          tree_age [NODES];
  logic [IDX_W-1:0]             tree_idx [NODES];
  logic                         node_ok  [P-1];
  logic [AGE_BITS-1:0]          node_age [P-1];
  logic [IDX_W-1:0]             node_idx [P-1];

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func   <= func;
      req_vol    <= volume_id;
      req_sec    <= sector[SECTOR_BITS-1:0];
      req_tick   <= tick[AGE_BITS-1:0];
      req_target <= target_entry;
      req_failed <= fill_failed;
    end
  end

  // Parallel tag compare, registered.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_r[i] <= entry_valid[i] && (entry_volume[i] == req_vol) &&
                    (entry_sector[i] == req_sec);
    end
  end

  // The lowest matching entry is the hit.
  always_comb begin
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
    end
    any_hit = |match_r;
  end

  assign tgt_idx      = IDX_W'(req_target);
  assign tgt_in_range = int'(req_target) < ENTRIES;

  // Merge registered nodes and leaves; padding leaves never win.
  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      if (n < P - 1) begin
        tree_ok[n]  = node_ok[n];
        tree_age[n] = node_age[n];
        tree_idx[n] = node_idx[n];
      end else if (n - (P - 1) < ENTRIES) begin
        tree_ok[n]  = 1'b1;
        tree_age[n] = entry_age[n - (P - 1)];
        tree_idx[n] = IDX_W'(n - (P - 1));
      end else begin
        tree_ok[n]  = 1'b0;
        tree_age[n] = '0;
        tree_idx[n] = IDX_W'(n - (P - 1));
      end
    end
  end

  // Each node keeps the smaller age of its children; the higher index wins ties.
  always_ff @(posedge clk) begin
    for (int n = 0; n < P - 1; n++) begin
      if (tree_ok[2*n+2] && (!tree_ok[2*n+1] || tree_age[2*n+2] <= tree_age[2*n+1])) begin
        node_ok[n]  <= 1'b1;
        node_age[n] <= tree_age[2*n+2];
        node_idx[n] <= tree_idx[2*n+2];
      end else begin
        node_ok[n]  <= tree_ok[2*n+1];
        node_age[n] <= tree_age[2*n+1];
        node_idx[n] <= tree_idx[2*n+1];
      end
    end
  end

  // Tag store update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i]  <= 1'b0;
        entry_volume[i] <= '0;
        entry_sector[i] <= '0;
        entry_age[i]    <= '0;
      end
    end else if (cmd.commit) begin
      if (req_func == cblc_pkg::FUNC_INVALIDATE) begin
        if (tgt_in_range) entry_valid[tgt_idx] <= 1'b0;
      end else if (any_hit) begin
        entry_age[hit_idx] <= req_tick;
      end else if (!req_failed) begin
        entry_valid[tree_idx[0]]  <= 1'b1;
        entry_volume[tree_idx[0]] <= req_vol;
        entry_sector[tree_idx[0]] <= req_sec;
        entry_age[tree_idx[0]]    <= req_tick;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= 1'b0;
      fill_needed <= 1'b0;
      error       <= 1'b0;
      if (req_func == cblc_pkg::FUNC_INVALIDATE) begin
        entry   <= req_target;
        res_idx <= tgt_idx;
      end else if (any_hit) begin
        hit     <= 1'b1;
        entry   <= cblc_pkg::ENTRY_W'(hit_idx);
        res_idx <= hit_idx;
      end else begin
        entry       <= cblc_pkg::ENTRY_W'(tree_idx[0]);
        res_idx     <= tree_idx[0];
        fill_needed <= !req_failed;
        error       <= req_failed;
      end
    end
  end

  // A lookup that did not fail leaves its entry valid.
  `CBLC_ASSERT_NEXT(a_lookup_valid, cmd.commit && (req_func == cblc_pkg::FUNC_LOOKUP) && (any_hit || !req_failed), entry_valid[res_idx], "lookup entry not valid")
  // An invalidate in range clears its entry.
  `CBLC_ASSERT_NEXT(a_inval_clear, cmd.commit && (req_func == cblc_pkg::FUNC_INVALIDATE) && tgt_in_range, !entry_valid[tgt_idx], "entry still valid")
  // A hit never asks for a fill or reports an error.
  `CBLC_ASSERT_NEXT(a_hit_clean, cmd.commit, !(hit && (fill_needed || error)), "hit with fill or error")

endmodule

`default_nettype wire

### design/cluster_buffer_lru_cache.sv
// Top level of the 16-entry fully associative sector buffer cache (tags and LRU).
// Instantiates cblc_ctrl and cblc_dp; depends on cblc_pkg.
//
//   Channel  Handshake            Fields
//   in       in_valid / in_stall  func volume_id sector tick target_entry fill_failed
//   out      out_valid / out_stall hit entry fill_needed error
//
// A request is taken only in the idle state; the controller then waits while the registered
// minimum-age tree settles, one level per index bit, and commits the result when the output
// register is free. No new request is taken until that commit.
// Synchronous reset clears all valid bits, tags and ages.
// A finished result waits in the output register while the next request is taken;
// a held result stalls only the commit of the following request.
`default_nettype none

module cluster_buffer_lru_cache #(
  parameter int ENTRIES     = cblc_pkg::DEF_ENTRIES,
  parameter int SECTOR_BITS = cblc_pkg::DEF_SECTOR_BITS,
  parameter int AGE_BITS    = cblc_pkg::DEF_AGE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           func,
  input  wire logic [cblc_pkg::VOL_W-1:0]     volume_id,
  input  wire logic [cblc_pkg::SECTOR_W-1:0]  sector,
  input  wire logic [cblc_pkg::TICK_W-1:0]    tick,
  input  wire logic [cblc_pkg::ENTRY_W-1:0]   target_entry,
  input  wire logic                           fill_failed,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                hit,
  output logic [cblc_pkg::ENTRY_W-1:0]        entry,
  output logic                                fill_needed,
  output logic                                error
);

  cblc_pkg::ctrl_cmd_t cmd;

  // Sequencing and handshakes.
  cblc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Tag store, replacement choice and result register.
  cblc_dp #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .volume_id    (volume_id),
    .sector       (sector),
    .tick         (tick),
    .target_entry (target_entry),
    .fill_failed  (fill_failed),
    .hit          (hit),
    .entry        (entry),
    .fill_needed  (fill_needed),
    .error        (error)
  );

endmodule

`default_nettype wire

### dv/cluster_buffer_lru_cache_tb.sv
// Self-checking testbench for the sector buffer cache: tag match, least-age victim
// selection, failed fills and invalidation, over random handshake timing.
// Depends on cblc_pkg and the cluster_buffer_lru_cache top level only.
`timescale 1ns / 100ps

module cluster_buffer_lru_cache_tb;
  import cblc_pkg::*;

  localparam int ENTRIES         = DEF_ENTRIES;
  localparam int LATENCY         = $clog2(ENTRIES) + 2;
  localparam int QUIET_LIMIT     = 4000;
  localparam int RANDOM_REQUESTS = 800;
  localparam int TAG_POOL        = 24;
  localparam int MAX_PRINTS      = 40;

  typedef struct packed {
    logic                hit;
    logic [ENTRY_W-1:0]  entry;
    logic                fill_needed;
    logic                error;
  } cache_result_t;

  typedef struct packed {
    logic                func;
    logic [VOL_W-1:0]    volume_id;
    logic [SECTOR_W-1:0] sector;
    logic [TICK_W-1:0]   tick;
    logic [ENTRY_W-1:0]  target_entry;
    logic                fill_failed;
  } cache_request_t;

  typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // Tag store model and queue of results still owed by the block.
  class cache_scoreboard;
    bit                  tag_valid[ENTRIES];
    logic [VOL_W-1:0]    tag_volume[ENTRIES];
    logic [SECTOR_W-1:0] tag_sector[ENTRIES];
    logic [TICK_W-1:0]   tag_age[ENTRIES];
    cache_result_t       owed_results[$];
    int mismatches = 0;
    int checked    = 0;
    int hits       = 0;
    int fills      = 0;
    int failed     = 0;
    int invals     = 0;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_valid[i]  = 1'b0;
        tag_volume[i] = '0;
        tag_sector[i] = '0;
        tag_age[i]    = '0;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one accepted request to the tag store and queue its result.
    function void note_request(cache_request_t rq);
      cache_result_t r;
      int            victim;
      bit            found;
      r      = '0;
      found  = 1'b0;
      victim = 0;
      if (rq.func == FUNC_INVALIDATE) begin
        if (int'(rq.target_entry) < ENTRIES) tag_valid[rq.target_entry] = 1'b0;
        r.entry = rq.target_entry;
        invals++;
      end else begin
        // The lowest matching index wins a hit.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && tag_valid[i] && tag_volume[i] == rq.volume_id &&
              tag_sector[i] == rq.sector) begin
            tag_age[i] = rq.tick;
            r.hit      = 1'b1;
            r.entry    = ENTRY_W'(i);
            found      = 1'b1;
          end
        end
        if (found) begin
          hits++;
        end else begin
          // Least age is the victim; equal ages go to the higher index.
          for (int i = 1; i < ENTRIES; i++) begin
            if (tag_age[i] <= tag_age[victim]) victim = i;
          end
          r.entry = ENTRY_W'(victim);
          if (rq.fill_failed) begin
            r.error = 1'b1;
            failed++;
          end else begin
            tag_valid[victim]  = 1'b1;
            tag_volume[victim] = rq.volume_id;
            tag_sector[victim] = rq.sector;
            tag_age[victim]    = rq.tick;
            r.fill_needed      = 1'b1;
            fills++;
          end
        end
      end
      owed_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_PRINTS)
        $display("%0t: mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest owed one.
    task check_result(cache_result_t got);
      cache_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected result", 32'(got), 32'h0);
      end else begin
        want = owed_results.pop_front();
        checked++;
        if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
        if (got.entry !== want.entry) report("entry", 32'(got.entry), 32'(want.entry));
        if (got.fill_needed !== want.fill_needed)
          report("fill_needed", 32'(got.fill_needed), 32'(want.fill_needed));
        if (got.error !== want.error) report("error", 32'(got.error), 32'(want.error));
      end
    endtask
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                func         = FUNC_LOOKUP;
  logic [VOL_W-1:0]    volume_id    = '0;
  logic [SECTOR_W-1:0] sector       = '0;
  logic [TICK_W-1:0]   tick         = '0;
  logic [ENTRY_W-1:0]  target_entry = '0;
  logic                fill_failed  = 1'b0;
  logic                out_stall    = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                hit;
  logic [ENTRY_W-1:0]  entry;
  logic                fill_needed;
  logic                error;

  cache_scoreboard sb = new();

  int       burst_left  = 0;
  int       quiet_count = 0;
  int       rx_left     = 0;
  rx_mode_t rx_mode     = RX_READY;

  logic [VOL_W-1:0]    pool_volume[TAG_POOL];
  logic [SECTOR_W-1:0] pool_sector[TAG_POOL];
  logic [TICK_W-1:0]   tick_now = '0;

  always #1 clk = ~clk;

  cluster_buffer_lru_cache i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .volume_id    (volume_id),
    .sector       (sector),
    .tick         (tick),
    .target_entry (target_entry),
    .fill_failed  (fill_failed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .entry        (entry),
    .fill_needed  (fill_needed),
    .error        (error)
  );

  // Watch both channels, predict on each accepted request, check each result.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request('{func, volume_id, sector, tick, target_entry, fill_failed});
    if (!rst && out_valid && !out_stall)
      sb.check_result('{hit, entry, fill_needed, error});
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles.", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver picks a new stall habit at random whenever its current run ends.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_READY:  out_stall <= 1'b0;
      RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      default:   out_stall <= ~out_stall;
    endcase
  end

  function automatic cache_request_t lookup(logic [VOL_W-1:0] v, logic [SECTOR_W-1:0] s,
                                            logic [TICK_W-1:0] t, logic ff);
    return '{FUNC_LOOKUP, v, s, t, ENTRY_W'($urandom), ff};
  endfunction

  function automatic cache_request_t invalidate(logic [ENTRY_W-1:0] idx);
    return '{FUNC_INVALIDATE, VOL_W'($urandom), $urandom, $urandom, idx,
             1'($urandom)};
  endfunction

  // Drive one request, opening a new burst after a random gap when the last one ran out.
  task automatic issue(cache_request_t rq);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 16) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    func         <= rq.func;
    volume_id    <= rq.volume_id;
    sector       <= rq.sector;
    tick         <= rq.tick;
    target_entry <= rq.target_entry;
    fill_failed  <= rq.fill_failed;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every owed result has been taken.
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    cache_request_t rq;
    int             k;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-cache ties, extremes, volume mismatch, failed fills, invalidates.
    issue(lookup(2'd1, 32'h0, 32'h0, 1'b0));
    issue(lookup(2'd1, 32'h0, 32'h1, 1'b0));
    issue(lookup(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    issue(lookup(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    issue(lookup(2'd3, 32'h0, 32'h2, 1'b0));
    issue(lookup(2'd2, 32'h0, 32'h3, 1'b0));
    issue(lookup(2'd1, 32'h0, 32'h4, 1'b1));
    issue(invalidate(4'd15));
    issue(lookup(2'd1, 32'h0, 32'h5, 1'b0));
    issue(invalidate(4'd0));
    issue(invalidate(4'd15));
    issue(lookup(2'd3, 32'h0, 32'h8000_0000, 1'b0));
    issue(lookup(2'd2, 32'hA5A5_5A5A, 32'h6, 1'b0));
    issue(lookup(2'd1, 32'h5A5A_A5A5, 32'h7, 1'b0));
    for (int i = 0; i < 8; i++)
      issue(lookup(VOL_W'(i), 32'h1 << (4 * i + 1), TICK_W'(8 + i), 1'b0));
    issue(lookup(2'd3, 32'hDEAD_0001, 32'h10, 1'b0));
    issue(lookup(2'd0, 32'h0, 32'h0, 1'b1));
    issue(invalidate(ENTRY_W'($urandom)));
    drain_results();

    // A pool of tags slightly larger than the cache keeps hits and evictions both common.
    for (int i = 0; i < TAG_POOL; i++) begin
      pool_volume[i] = VOL_W'($urandom);
      pool_sector[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
    end
    tick_now = 32'h20;

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 200 == 199) drain_results();
      if ($urandom_range(0, 19) == 0) tick_now = $urandom;
      else tick_now = tick_now + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        rq = invalidate(ENTRY_W'($urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        rq = lookup(VOL_W'($urandom), $urandom, tick_now, ($urandom_range(0, 7) == 0));
      end else begin
        k  = $urandom_range(0, TAG_POOL - 1);
        rq = lookup(pool_volume[k], pool_sector[k], tick_now, ($urandom_range(0, 7) == 0));
      end
      issue(rq);
    end

    // Let the last results come out, then give the block time to show anything extra.
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    $display("Ran %0d lookups and invalidates: %0d hits, %0d fills, %0d failed fills, %0d invalidates.",
             sb.hits + sb.fills + sb.failed + sb.invals, sb.hits, sb.fills, sb.failed,
             sb.invals);
    $display("Checked %0d results with %0d mismatches, %0d still owed.",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/cblc_pkg.sv
design/cblc_ctrl.sv
design/cblc_dp.sv
design/cluster_buffer_lru_cache.sv
dv/cluster_buffer_lru_cache_tb.sv
